@@ sv/mlq_pkg.sv @@
// shared constants for the multilevel priority ready queue
`default_nettype none

package mlq_pkg;

    localparam int LEVELS_DEF = 140;
    localparam int DEPTH_DEF  = 16;

    localparam int LEVEL_W  = 8;
    localparam int KEY_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + HANDLE_W;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

endpackage

`default_nettype wire

@@ sv/multilevel_priority_ready_queue.sv @@
// multilevel priority ready queue: sorted insert per level, lowest-level dequeue
// enqueue: level check, count read, tail-first compare moving larger keys back, then insert;
//   a bad level (multilevel mode) or a full level is rejected; dequeue: level scan, count read,
//   head read, slide-up of the rest, finish; the result strobe is registered; one item at a time,
//   a start taken only while idle; reset: counts read as zero through per-level valid bits,
//   no clearing pass, entries not cleared, mode resets to multilevel; the receiver cannot stall
`default_nettype none

module multilevel_priority_ready_queue #(
    parameter int LEVELS = mlq_pkg::LEVELS_DEF,
    parameter int DEPTH  = mlq_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command side
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          opcode,
    input  wire logic [mlq_pkg::LEVEL_W-1:0]   level,
    input  wire logic [mlq_pkg::KEY_W-1:0]     sort_key,
    input  wire logic [mlq_pkg::HANDLE_W-1:0]  process_handle,
    // result side
    output logic                               done,
    output logic      [mlq_pkg::STATUS_W-1:0]  status,
    output logic                               handle_valid,
    output logic      [mlq_pkg::HANDLE_W-1:0]  out_handle,
    output logic      [mlq_pkg::LEVEL_W-1:0]   out_level,
    output logic      [mlq_pkg::KEY_W-1:0]     out_key,
    // mode register
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata
);

    localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SCAN_W = $clog2(LEVELS + 1);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int EA_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W    = mlq_pkg::KEY_W;
    localparam int HANDLE_W = mlq_pkg::HANDLE_W;
    localparam int ENTRY_W  = mlq_pkg::ENTRY_W;

    localparam logic [mlq_pkg::LEVEL_W:0] LEVELS_V = (mlq_pkg::LEVEL_W + 1)'(LEVELS);
    localparam logic [CNT_W-1:0]          DEPTH_V  = CNT_W'(DEPTH);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ENQ_CHK = 4'd1;
    localparam logic [3:0] S_ENQ_CNT = 4'd2;
    localparam logic [3:0] S_SH_CMP  = 4'd3;
    localparam logic [3:0] S_INS     = 4'd4;
    localparam logic [3:0] S_DQ_SCAN = 4'd5;
    localparam logic [3:0] S_DQ_CNT  = 4'd6;
    localparam logic [3:0] S_DQ_HEAD = 4'd7;
    localparam logic [3:0] S_DQ_SH   = 4'd8;
    localparam logic [3:0] S_DQ_FIN  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       mode_reg;

    // item held while it is worked on
    logic [mlq_pkg::LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [HANDLE_W-1:0]         hdl_reg, hdl_next;
    logic [EA_W-1:0]             base_reg, base_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            pos_reg, pos_next;
    logic [SCAN_W-1:0]           scan_reg, scan_next;
    logic [ENTRY_W-1:0]          head_reg, head_next;

    // per-level count valid and non-empty flags
    logic [LEVELS-1:0] cvalid_reg;
    logic [LEVELS-1:0] nempty_reg;

    // result registers
    logic                         done_reg, done_next;
    logic [mlq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         hvalid_reg, hvalid_next;
    logic [HANDLE_W-1:0]          ohandle_reg, ohandle_next;
    logic [mlq_pkg::LEVEL_W-1:0]  olevel_reg, olevel_next;
    logic [KEY_W-1:0]             okey_reg, okey_next;

    // count memory ports
    logic [LIDX_W-1:0] cr_addr;
    logic [CNT_W-1:0]  cr_rdata;
    logic              cw_en;
    logic [CNT_W-1:0]  cw_data;
    logic [CNT_W-1:0]  cnt_cur;
    logic [LIDX_W-1:0] lidx;
    logic [LIDX_W-1:0] sidx;

    // entry memory ports
    logic [EA_W-1:0]    er_addr;
    logic [ENTRY_W-1:0] er_rdata;
    logic               ew_en;
    logic [EA_W-1:0]    ew_addr;
    logic [ENTRY_W-1:0] ew_data;

    logic [SCAN_W-1:0] scan_last;
    logic [KEY_W-1:0]  rd_key;

    assign lidx      = lvl_reg[LIDX_W-1:0];
    assign sidx      = scan_reg[LIDX_W-1:0];
    assign cnt_cur   = cvalid_reg[lidx] ? cr_rdata : '0;
    assign scan_last = mode_reg ? SCAN_W'(LEVELS) : SCAN_W'(1);
    assign rd_key    = er_rdata[ENTRY_W-1:HANDLE_W];

    // count lookup goes to the scanned level during a dequeue search
    assign cr_addr   = (state_reg == S_DQ_SCAN) ? sidx : lidx;
    // base address of a level's slots, registered before any entry access
    assign base_next = ((state_reg == S_ENQ_CHK) || (state_reg == S_DQ_SCAN))
                       ? EA_W'(cr_addr) * EA_W'(DEPTH) : base_reg;

    mlq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (LEVELS),
        .AW    (LIDX_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cw_en),
        .waddr (lidx),
        .wdata (cw_data),
        .raddr (cr_addr),
        .rdata (cr_rdata)
    );

    mlq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .AW    (EA_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ew_en),
        .waddr (ew_addr),
        .wdata (ew_data),
        .raddr (er_addr),
        .rdata (er_rdata)
    );

    // sequencer: at most one entry read and one entry write per cycle
    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        key_next     = key_reg;
        hdl_next     = hdl_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        scan_next    = scan_reg;
        head_next    = head_reg;
        er_addr      = base_reg;
        ew_en        = 1'b0;
        ew_addr      = base_reg + EA_W'(pos_reg);
        ew_data      = {key_reg, hdl_reg};
        cw_en        = 1'b0;
        cw_data      = cnt_reg + CNT_W'(1);
        done_next    = 1'b0;
        status_next  = mlq_pkg::ST_OK;
        hvalid_next  = 1'b0;
        ohandle_next = '0;
        olevel_next  = '0;
        okey_next    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // single-queue mode folds every enqueue onto level zero
                    lvl_next  = mode_reg ? level : '0;
                    key_next  = sort_key;
                    hdl_next  = process_handle;
                    scan_next = '0;
                    state_next = (opcode == mlq_pkg::OP_DEQ) ? S_DQ_SCAN : S_ENQ_CHK;
                end
            end

            S_ENQ_CHK:
            begin
                if (mode_reg && ({1'b0, lvl_reg} >= LEVELS_V))
                begin
                    done_next   = 1'b1;
                    status_next = mlq_pkg::ST_INVALID;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_ENQ_CNT;
                end
            end

            S_ENQ_CNT:
            begin
                cnt_next = cnt_cur;
                pos_next = cnt_cur;
                if (cnt_cur == DEPTH_V)
                begin
                    done_next   = 1'b1;
                    status_next = mlq_pkg::ST_FULL;
                    state_next  = S_IDLE;
                end
                else if (cnt_cur == '0)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    // look at the tail entry first
                    er_addr    = base_reg + EA_W'(cnt_cur - CNT_W'(1));
                    state_next = S_SH_CMP;
                end
            end

            S_SH_CMP:
            begin
                // move larger keys back one slot, stop at an equal or smaller key
                if (rd_key > key_reg)
                begin
                    ew_en    = 1'b1;
                    ew_data  = er_rdata;
                    pos_next = pos_reg - CNT_W'(1);
                    if (pos_reg == CNT_W'(1))
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        er_addr = base_reg + EA_W'(pos_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                ew_en      = 1'b1;
                cw_en      = 1'b1;
                cw_data    = cnt_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DQ_SCAN:
            begin
                if (scan_reg >= scan_last)
                begin
                    done_next   = 1'b1;
                    status_next = mlq_pkg::ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else if (nempty_reg[sidx])
                begin
                    lvl_next   = (mlq_pkg::LEVEL_W)'(scan_reg);
                    state_next = S_DQ_CNT;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end

            S_DQ_CNT:
            begin
                cnt_next   = cnt_cur;
                er_addr    = base_reg;
                state_next = S_DQ_HEAD;
            end

            S_DQ_HEAD:
            begin
                head_next = er_rdata;
                pos_next  = CNT_W'(1);
                if (cnt_reg > CNT_W'(1))
                begin
                    er_addr    = base_reg + EA_W'(1);
                    state_next = S_DQ_SH;
                end
                else
                begin
                    state_next = S_DQ_FIN;
                end
            end

            S_DQ_SH:
            begin
                // slide each remaining entry up by one slot
                ew_en   = 1'b1;
                ew_addr = base_reg + EA_W'(pos_reg - CNT_W'(1));
                ew_data = er_rdata;
                if ((pos_reg + CNT_W'(1)) < cnt_reg)
                begin
                    er_addr  = base_reg + EA_W'(pos_reg + CNT_W'(1));
                    pos_next = pos_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DQ_FIN;
                end
            end

            S_DQ_FIN:
            begin
                cw_en        = 1'b1;
                cw_data      = cnt_reg - CNT_W'(1);
                done_next    = 1'b1;
                hvalid_next  = 1'b1;
                ohandle_next = head_reg[HANDLE_W-1:0];
                olevel_next  = lvl_reg;
                okey_next    = head_reg[ENTRY_W-1:HANDLE_W];
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b1;
            done_reg   <= 1'b0;
            cvalid_reg <= '0;
            nempty_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cw_en)
            begin
                cvalid_reg[lidx] <= 1'b1;
                nempty_reg[lidx] <= (cw_data != '0);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg     <= lvl_next;
        key_reg     <= key_next;
        hdl_reg     <= hdl_next;
        base_reg    <= base_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        scan_reg    <= scan_next;
        head_reg    <= head_next;
        status_reg  <= status_next;
        hvalid_reg  <= hvalid_next;
        ohandle_reg <= ohandle_next;
        olevel_reg  <= olevel_next;
        okey_reg    <= okey_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign handle_valid = hvalid_reg;
    assign out_handle   = ohandle_reg;
    assign out_level    = olevel_reg;
    assign out_key      = okey_reg;

endmodule

`default_nettype wire

@@ sv/mlq_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module mlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
